/* rtl/rpn_pkg.sv */
// ---------------------------------------------------------------------------
// rpn_pkg
// Shared types, operation and status codes, and the microcode program of the
// stack calculator.
// ---------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  // operation codes of an input beat
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // status codes of a result beat
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIV0  = 2'd3;

  // divider runs one quotient bit per step
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned ITER_W    = $clog2(DIV_STEPS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_STEPS - 1);

  // datapath action of one microcode step
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LATCH,
    ACT_LOAD_AB,
    ACT_ALU,
    ACT_WB,
    ACT_PUSH,
    ACT_SET_OVER,
    ACT_SET_UNDER,
    ACT_SET_DIV0,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_FIX,
    ACT_EMIT
  } act_t;

  // jump condition of one microcode step
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_BEAT,
    C_IS_PUSH,
    C_NOT_ARITH,
    C_FEW,
    C_FULL,
    C_IS_DIV,
    C_B_ZERO,
    C_ITER_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic beat;
    logic is_push;
    logic not_arith;
    logic few;
    logic full;
    logic is_div;
    logic b_zero;
    logic iter_more;
    logic out_busy;
  } flags_t;

  // microcode addresses
  localparam upc_t UA_FIN       = 5'd0;
  localparam upc_t UA_FETCH     = 5'd1;
  localparam upc_t UA_DEC_PUSH  = 5'd2;
  localparam upc_t UA_DEC_ARITH = 5'd3;
  localparam upc_t UA_DEC_FEW   = 5'd4;
  localparam upc_t UA_LOAD      = 5'd5;
  localparam upc_t UA_ALU       = 5'd6;
  localparam upc_t UA_WB        = 5'd7;
  localparam upc_t UA_PUSH      = 5'd8;
  localparam upc_t UA_PUSH_WR   = 5'd9;
  localparam upc_t UA_OVER      = 5'd10;
  localparam upc_t UA_UNDER     = 5'd11;
  localparam upc_t UA_DIV       = 5'd12;
  localparam upc_t UA_DIV_INIT  = 5'd13;
  localparam upc_t UA_DIV_STEP  = 5'd14;
  localparam upc_t UA_DIV_FIX   = 5'd15;
  localparam upc_t UA_DIV0      = 5'd16;

  // control store: taken jump goes to target, otherwise to the next step
  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    case (addr)
      UA_FIN:       w = '{ACT_EMIT,      C_OUT_BUSY,  UA_FIN};
      UA_FETCH:     w = '{ACT_LATCH,     C_NO_BEAT,   UA_FETCH};
      UA_DEC_PUSH:  w = '{ACT_NOP,       C_IS_PUSH,   UA_PUSH};
      UA_DEC_ARITH: w = '{ACT_NOP,       C_NOT_ARITH, UA_FIN};
      UA_DEC_FEW:   w = '{ACT_NOP,       C_FEW,       UA_UNDER};
      UA_LOAD:      w = '{ACT_LOAD_AB,   C_IS_DIV,    UA_DIV};
      UA_ALU:       w = '{ACT_ALU,       C_NEXT,      UA_FIN};
      UA_WB:        w = '{ACT_WB,        C_ALWAYS,    UA_FIN};
      UA_PUSH:      w = '{ACT_NOP,       C_FULL,      UA_OVER};
      UA_PUSH_WR:   w = '{ACT_PUSH,      C_ALWAYS,    UA_FIN};
      UA_OVER:      w = '{ACT_SET_OVER,  C_ALWAYS,    UA_FIN};
      UA_UNDER:     w = '{ACT_SET_UNDER, C_ALWAYS,    UA_FIN};
      UA_DIV:       w = '{ACT_NOP,       C_B_ZERO,    UA_DIV0};
      UA_DIV_INIT:  w = '{ACT_DIV_INIT,  C_NEXT,      UA_FIN};
      UA_DIV_STEP:  w = '{ACT_DIV_STEP,  C_ITER_MORE, UA_DIV_STEP};
      UA_DIV_FIX:   w = '{ACT_DIV_FIX,   C_ALWAYS,    UA_WB};
      UA_DIV0:      w = '{ACT_SET_DIV0,  C_ALWAYS,    UA_FIN};
      default:      w = '{ACT_NOP,       C_ALWAYS,    UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/rpn_if.sv */
// ---------------------------------------------------------------------------
// rpn channel interfaces
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface rpn_cmd_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  operation;
  logic signed [31:0] number;

  modport source (output valid, output operation, output number, input ready);
  modport sink   (input valid, input operation, input number, output ready);
endinterface

interface rpn_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] top_value;
  logic        [2:0]  depth;

  modport source (output valid, output status, output top_value, output depth,
                  input ready);
  modport sink   (input valid, input status, input top_value, input depth,
                  output ready);
endinterface

`default_nettype wire

/* rtl/rpn_ram.sv */
// ---------------------------------------------------------------------------
// rpn_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/rpn_seq.sv */
// ---------------------------------------------------------------------------
// rpn_seq
// Microcode sequencer: step counter, control store lookup and jump logic.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_seq import rpn_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire flags_t flags,
  output      act_t   act
);

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   taken;

  // control word of the current step
  assign uw  = ucode(upc);
  assign act = uw.act;

  // jump condition select
  always_comb begin
    case (uw.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_BEAT:   taken = !flags.beat;
      C_IS_PUSH:   taken = flags.is_push;
      C_NOT_ARITH: taken = flags.not_arith;
      C_FEW:       taken = flags.few;
      C_FULL:      taken = flags.full;
      C_IS_DIV:    taken = flags.is_div;
      C_B_ZERO:    taken = flags.b_zero;
      C_ITER_MORE: taken = flags.iter_more;
      C_OUT_BUSY:  taken = flags.out_busy;
      default:     taken = 1'b0;
    endcase
    upc_next = taken ? uw.target : upc + 5'd1;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rpn_dpath.sv */
// ---------------------------------------------------------------------------
// rpn_dpath
// Stack datapath: operand registers, ALU, shift-subtract divider, stack RAM
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_dpath import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire act_t act,
  output      flags_t flags,
  rpn_cmd_if.sink   cmd,
  rpn_rsp_if.source rsp
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_m2;
  logic [CW+2:0]     cnt_wide;
  logic [2:0]        op;
  logic [31:0]       num;
  logic [1:0]        status;
  logic [31:0]       top;
  logic [31:0]       a;
  logic [31:0]       b;
  logic [31:0]       res;
  logic [31:0]       alu_out;
  logic [31:0]       rem;
  logic [31:0]       quo;
  logic [31:0]       dvsr;
  logic [ITER_W-1:0] iter;
  logic              neg;
  logic [32:0]       shifted;
  logic [32:0]       diff;
  logic              out_busy;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;

  assign cnt_m2   = cnt - CW'(2);
  assign cnt_wide = (CW + 3)'(cnt);
  assign out_busy = rsp.valid && !rsp.ready;
  assign cmd.ready = (act == ACT_LATCH);

  // status toward the sequencer
  always_comb begin
    flags.beat      = cmd.valid;
    flags.is_push   = (op == OP_PUSH);
    flags.not_arith = (op > OP_DIV);
    flags.few       = (cnt < CW'(2));
    flags.full      = (cnt == CW'(STACK_DEPTH));
    flags.is_div    = (op == OP_DIV);
    flags.b_zero    = (b == 32'd0);
    flags.iter_more = (iter != ITER_LAST);
    flags.out_busy  = out_busy;
  end

  // stack storage for all entries, the top one also kept in a register
  assign ram_we    = (act == ACT_WB) || (act == ACT_PUSH);
  assign ram_waddr = (act == ACT_PUSH) ? cnt[AW-1:0] : cnt_m2[AW-1:0];
  assign ram_wdata = (act == ACT_PUSH) ? num : res;

  rpn_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  // add, subtract and low word of multiply
  always_comb begin
    case (op)
      OP_ADD:  alu_out = a + b;
      OP_SUB:  alu_out = a - b;
      default: alu_out = a * b;
    endcase
  end

  // one restoring divide step on magnitudes
  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, dvsr};

  // stack count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (act == ACT_PUSH) begin
      cnt <= cnt + CW'(1);
    end else if (act == ACT_WB) begin
      cnt <= cnt - CW'(1);
    end
  end

  // operand, top and divider registers
  always_ff @(posedge clk) begin
    case (act)
      ACT_LATCH: begin
        if (cmd.valid) begin
          op     <= cmd.operation;
          num    <= $unsigned(cmd.number);
          status <= ST_OK;
        end
      end
      ACT_LOAD_AB: begin
        a <= ram_rdata;
        b <= top;
      end
      ACT_ALU: begin
        res <= alu_out;
      end
      ACT_WB: begin
        top <= res;
      end
      ACT_PUSH: begin
        top <= num;
      end
      ACT_SET_OVER:  status <= ST_OVER;
      ACT_SET_UNDER: status <= ST_UNDER;
      ACT_SET_DIV0:  status <= ST_DIV0;
      ACT_DIV_INIT: begin
        quo  <= a[31] ? (32'd0 - a) : a;
        dvsr <= b[31] ? (32'd0 - b) : b;
        rem  <= '0;
        iter <= '0;
        neg  <= a[31] ^ b[31];
      end
      ACT_DIV_STEP: begin
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        iter <= iter + ITER_W'(1);
      end
      ACT_DIV_FIX: begin
        res <= neg ? (32'd0 - quo) : quo;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (act == ACT_EMIT && !out_busy) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act == ACT_EMIT && !out_busy) begin
      rsp.status    <= status;
      rsp.top_value <= (cnt == '0) ? 32'sd0 : $signed(top);
      rsp.depth     <= cnt_wide[2:0];
    end
  end

  // count never passes the stack size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // an operator writes back only with two operands held
  a_wb_operands: assert property (@(posedge clk) disable iff (rst)
    (act == ACT_WB) |-> (cnt >= CW'(2)))
    else $error("write-back with fewer than two entries");

  // a push lands only on a stack with room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (act == ACT_PUSH) |-> (cnt < CW'(STACK_DEPTH)))
    else $error("push on full stack");

  // a new result beat appears only from the emit step
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(act == ACT_EMIT))
    else $error("result beat without emit step");

endmodule

`default_nettype wire

/* rtl/rpn_stack_calculator.sv */
// The next command is taken at the fetch step that follows the emit step; a divide
// holds the block through the 32-step shift-subtract loop in the datapath.
// A waiting result does not block the next command until its own emit step.
// Reset (synchronous, active high) empties the stack; RAM contents are kept.
// ---------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish integer calculator over a small stack, run by a microcode
// sequencer over a plain datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 4
) (
  input wire logic  clk,
  input wire logic  rst,
  rpn_cmd_if.sink   cmd,
  rpn_rsp_if.source rsp
);

  act_t   act;
  flags_t flags;

  // control sequencer
  rpn_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .act   (act)
  );

  // stack datapath
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk   (clk),
    .rst   (rst),
    .act   (act),
    .flags (flags),
    .cmd   (cmd),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

/* tb/rpn_stack_calculator_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_stack_calculator_tb
// Self-checking bench for the stack calculator. A directed list covers the
// wrap cases, the error statuses and the unused operation codes. A random
// stream of mostly well-formed push/operator sequences follows. Every
// command beat is run through a local model of the stack, and each result
// beat is compared field by field.
// ---------------------------------------------------------------------------

module rpn_stack_calculator_tb;
  import rpn_pkg::*;

  localparam int unsigned STACK_DEPTH  = 4;
  localparam int unsigned RANDOM_CMDS  = 1200;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned STALL_LIMIT  = 1000;

  // operation codes the block ignores
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] NEG_ONE = 32'hffff_ffff;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] num;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] top;
    logic [2:0]  depth;
  } calc_result_t;

  logic clk;
  logic rst;

  rpn_cmd_if cmd_bus ();
  rpn_rsp_if rsp_bus ();

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  // pending commands and results still owed by the block
  cmd_item_t    cmd_q[$];
  calc_result_t result_q[$];

  // local copy of the stack
  logic [31:0] stack_mem[STACK_DEPTH];
  int unsigned held;

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned cmd_gap_left;
  int unsigned rsp_stall_left;
  int unsigned push_count;
  int unsigned arith_count;
  int unsigned unused_count;
  int unsigned status_count[4];

  wire calm = (cmd_q.size() < CALM_TAIL);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_cmd(input logic [2:0] op, input logic [31:0] num);
    cmd_item_t c;
    c.op  = op;
    c.num = num;
    cmd_q.push_back(c);
  endtask

  // signed division truncating toward zero, done on magnitudes
  function automatic logic [31:0] quot_trunc(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn;
    logic [31:0] md;
    logic [31:0] q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q  = mn / md;
    return (n[31] ^ d[31]) ? -q : q;
  endfunction

  // apply one command to the local stack and return the result it gives
  function automatic calc_result_t calc_step(input logic [2:0] op, input logic [31:0] num);
    calc_result_t r;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  val;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      push_count++;
      if (held >= STACK_DEPTH) begin
        r.status = ST_OVER;
      end else begin
        stack_mem[held] = num;
        held++;
      end
    end else if (op <= OP_DIV) begin
      arith_count++;
      if (held < 2) begin
        r.status = ST_UNDER;
      end else begin
        lhs = stack_mem[held-2];
        rhs = stack_mem[held-1];
        if (op == OP_DIV && rhs == '0) begin
          r.status = ST_DIV0;
        end else begin
          case (op)
            OP_ADD:  val = lhs + rhs;
            OP_SUB:  val = lhs - rhs;
            OP_MUL:  val = lhs * rhs;
            default: val = quot_trunc(lhs, rhs);
          endcase
          stack_mem[held-1] = '0;
          held--;
          stack_mem[held-1] = val;
        end
      end
    end else begin
      unused_count++;
    end
    r.top   = (held == 0) ? '0 : stack_mem[held-1];
    r.depth = 3'(held);
    status_count[r.status]++;
    return r;
  endfunction

  // operand mix: full range, small near zero, extremes, shifted, 1 to 1000
  function automatic logic [31:0] pick_number();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = 32'($urandom_range(0, 40)) - 32'd20;
      6: begin
        case ($urandom_range(0, 4))
          0:       v = INT_MIN;
          1:       v = INT_MAX;
          2:       v = NEG_ONE;
          3:       v = 32'd1;
          default: v = '0;
        endcase
      end
      7:       v = $urandom >> $urandom_range(1, 31);
      8:       v = -($urandom >> $urandom_range(1, 31));
      default: v = 32'($urandom_range(1, 1000));
    endcase
    return v;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
      cmd_gap_left  = 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        result_q.push_back(calc_step(cmd_bus.operation, cmd_bus.number));
        void'(cmd_q.pop_front());
      end
      if (cmd_bus.valid && !cmd_bus.ready) begin
        // hold the beat until it is taken
      end else if (cmd_gap_left != 0) begin
        cmd_gap_left--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        cmd_gap_left = $urandom_range(0, 14);
        cmd_bus.valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        cmd_bus.valid     <= 1'b1;
        cmd_bus.operation <= cmd_q[0].op;
        cmd_bus.number    <= cmd_q[0].num;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          if (rsp_bus.status !== result_q[0].status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp_bus.status, result_q[0].status));
          if (rsp_bus.top_value !== result_q[0].top)
            report_mismatch($sformatf("top_value got %08h want %08h",
                                      rsp_bus.top_value, result_q[0].top));
          if (rsp_bus.depth !== result_q[0].depth)
            report_mismatch($sformatf("depth got %0d want %0d",
                                      rsp_bus.depth, result_q[0].depth));
          void'(result_q.pop_front());
        end
      end
      if (rsp_stall_left != 0) begin
        rsp_stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        rsp_stall_left = $urandom_range(0, 14);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d commands and %0d results pending",
                 idle_cycles, cmd_q.size(), result_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned counted;
    int          depth_plan;
    int unsigned pick;
    logic [2:0]  op;
    bit          want_push;

    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.operation = OP_PUSH;
    cmd_bus.number    = '0;
    rsp_bus.ready     = 1'b0;
    held              = 0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    push_count        = 0;
    arith_count       = 0;
    unused_count      = 0;
    foreach (status_count[i]) status_count[i] = 0;
    foreach (stack_mem[i]) stack_mem[i] = '0;

    // directed: empty stack, wraps, errors, truncation
    queue_cmd(OP_ADD, '0);
    queue_cmd(OP_UNUSED_FIRST, 32'h1234_5678);
    queue_cmd(OP_PUSH, INT_MAX);
    queue_cmd(OP_MUL, '0);
    queue_cmd(OP_PUSH, 32'd1);
    queue_cmd(OP_ADD, NEG_ONE);
    queue_cmd(OP_PUSH, NEG_ONE);
    queue_cmd(OP_DIV, '0);
    queue_cmd(OP_PUSH, '0);
    queue_cmd(OP_DIV, '0);
    queue_cmd(OP_PUSH, 32'd5);
    queue_cmd(OP_PUSH, -32'd7);
    queue_cmd(OP_PUSH, 32'd123);
    queue_cmd(3'(OP_UNUSED_FIRST + 1), NEG_ONE);
    queue_cmd(OP_SUB, '0);
    queue_cmd(OP_DIV, '0);
    queue_cmd(OP_MUL, '0);
    queue_cmd(OP_PUSH, -32'd7);
    queue_cmd(OP_PUSH, 32'd2);
    queue_cmd(OP_DIV, '0);
    queue_cmd(OP_UNUSED_LAST, INT_MIN);
    queue_cmd(OP_SUB, '0);
    queue_cmd(OP_PUSH, INT_MIN);
    queue_cmd(OP_SUB, '0);

    // random: push/operator mix steered by the planned depth
    counted    = 0;
    depth_plan = 1;
    while (counted < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else begin
        if (depth_plan < 2)
          want_push = (pick < 85);
        else if (depth_plan >= STACK_DEPTH)
          want_push = (pick < 22);
        else
          want_push = (pick < 52);
        op = want_push ? OP_PUSH : 3'($urandom_range(OP_ADD, OP_DIV));
        counted++;
        if (op == OP_PUSH && depth_plan < STACK_DEPTH)
          depth_plan++;
        else if (op != OP_PUSH && depth_plan >= 2)
          depth_plan--;
      end
      queue_cmd(op, pick_number());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", result_q.size()));

    $display("covered %0d pushes, %0d operators and %0d ignored codes",
             push_count, arith_count, unused_count);
    $display("statuses seen: ok %0d, overflow %0d, underflow %0d, divide by zero %0d",
             status_count[ST_OK], status_count[ST_OVER], status_count[ST_UNDER],
             status_count[ST_DIV0]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* rpn_stack_calculator.f */
rtl/rpn_pkg.sv
rtl/rpn_if.sv
rtl/rpn_ram.sv
rtl/rpn_seq.sv
rtl/rpn_dpath.sv
rtl/rpn_stack_calculator.sv
tb/rpn_stack_calculator_tb.sv
